// ===== design/cache_hit_model_dm_fa_fifo_macros.svh =====
// Assertion helpers for the checker file of the hit-model block.
`ifndef CACHE_HIT_MODEL_DM_FA_FIFO_MACROS_SVH
`define CACHE_HIT_MODEL_DM_FA_FIFO_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define CHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the following cycle.
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/chm_pkg.sv =====
package chm_pkg;

	// Default sizing of the tag store.
	localparam int MAX_LINES_DEF  = 64;
	localparam int LINE_BYTES_DEF = 64;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FA    = 2'd0;
	localparam logic [1:0] CFG_SPLIT = 2'd1;
	localparam logic [1:0] CFG_LG    = 2'd2;

	// Reset value of the line count exponent.
	localparam logic [2:0] LG_RESET = 3'd6;

	// Configuration as seen by the lookup sequencer.
	typedef struct packed {
		logic       fa;
		logic       split;
		logic [2:0] lg;
	} chm_cfg_t;

	// Result handed from the sequencer to the output stage.
	typedef struct packed {
		logic done;
		logic hit;
	} chm_result_t;

endpackage

// ===== design/cache_hit_model_dm_fa_fifo.sv =====
// Steps: S_SCAN reads and compares, S_WRITE stores the tag on a miss, S_DONE hands over.
// Direct mapped compares the indexed line; fully associative scans up to 2^lg lines, one stored
// tag compared per cycle through the single tag RAM read port and one shared comparator.
// The next item is taken once the sequencer is idle, even while the previous result waits on
// the output; a result that the output register cannot take holds the sequencer in S_DONE.
// Reset (arst_n low): valid bits, FIFO state and totals clear; direct mapped, unified, lg 6.
module cache_hit_model_dm_fa_fifo import chm_pkg::*; #(
	parameter int MAX_LINES  = MAX_LINES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // address[31:0]
	input  logic [0:0]   s_axis_tuser,   // access_kind[0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata    // hit[0], access_total[64:1], hit_total[128:65]
);

	chm_cfg_t    cfg_q;
	chm_result_t res;
	logic        out_valid_q;
	logic        out_hit_q;
	logic [63:0] acc_q;
	logic [63:0] hits_q;
	logic        out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fa    <= 1'b0;
			cfg_q.split <= 1'b0;
			cfg_q.lg    <= LG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FA:    cfg_q.fa    <= cfg_wdata[0];
				CFG_SPLIT: cfg_q.split <= cfg_wdata[0];
				CFG_LG:    cfg_q.lg    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	chm_lookup #(
		.MAX_LINES  (MAX_LINES),
		.LINE_BYTES (LINE_BYTES)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_addr  (s_axis_tdata),
		.in_kind  (s_axis_tuser[0]),
		.out_free (out_free),
		.res      (res)
	);

	// Running totals double as the output payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			acc_q       <= '0;
			hits_q      <= '0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
			out_hit_q   <= res.hit;
			acc_q       <= acc_q + 64'd1;
			hits_q      <= hits_q + {63'd0, res.hit};
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, hits_q, acc_q, out_hit_q};

endmodule

// ===== design/chm_tag_ram.sv =====
module chm_tag_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 26
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/chm_lookup.sv =====
module chm_lookup import chm_pkg::*; #(
	parameter int MAX_LINES  = MAX_LINES_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  chm_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_addr,
	input  logic        in_kind,
	input  logic        out_free,
	output chm_result_t res
);

	localparam int OFF    = $clog2(LINE_BYTES + 1) - 1;
	localparam int TAG_W  = 32 - OFF;
	localparam int LG_MAX = $clog2(MAX_LINES + 1) - 1;
	localparam int LG_CAP = (LG_MAX > 7) ? 7 : LG_MAX;
	localparam int IDX_W  = LG_CAP;
	localparam int CNT_W  = IDX_W + 1;
	localparam int DEPTH  = 2 * MAX_LINES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [4:0] OFF5 = 5'(OFF);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [TAG_W-1:0]   tag_q;
	logic [IDX_W-1:0]   idx_q;
	logic               part_q;
	logic               fa_q;
	logic [2:0]         lg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_q;
	logic               hit_q;
	logic               cmp_vld_s1;
	logic               cmp_last_s1;
	logic [ADDR_W-1:0]  cmp_slot_s1;
	logic [DEPTH-1:0]   valid_q;
	logic [CNT_W-1:0]   fill_q   [2];
	logic [IDX_W-1:0]   oldest_q [2];

	logic [2:0]         lg_in;
	logic [CNT_W-1:0]   lines_in;
	logic [IDX_W-1:0]   mask_in;
	logic [4:0]         sh_in;
	logic               accept;
	logic [IDX_W-1:0]   scan_i;
	logic [ADDR_W-1:0]  rd_slot;
	logic               issue;
	logic [TAG_W-1:0]   rdata;
	logic               match;
	logic [CNT_W-1:0]   lines;
	logic [IDX_W-1:0]   mask;
	logic [CNT_W-1:0]   fill_cur;
	logic               room;
	logic [IDX_W-1:0]   vic_i;
	logic [ADDR_W-1:0]  wr_slot;
	logic               we;

	// Effective line count of the incoming item, clamped to the size of one partition.
	assign lg_in    = (cfg.lg > 3'(LG_CAP)) ? 3'(LG_CAP) : cfg.lg;
	assign lines_in = CNT_W'(1) << lg_in;
	assign mask_in  = IDX_W'(lines_in - CNT_W'(1));
	assign sh_in    = cfg.fa ? OFF5 : OFF5 + 5'(lg_in);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_ready = (state_q == S_IDLE);

	// Scan address: one line per cycle in associative mode, the indexed line otherwise.
	assign scan_i  = fa_q ? cnt_q[IDX_W-1:0] : idx_q;
	assign rd_slot = part_q ? ADDR_W'(MAX_LINES) + ADDR_W'(scan_i) : ADDR_W'(scan_i);
	assign issue   = (state_q == S_SCAN) && (cnt_q != n_q);

	// The single shared tag comparator.
	assign match = cmp_vld_s1 && valid_q[cmp_slot_s1] && (rdata == tag_q);

	// Victim choice on a miss.
	assign lines    = CNT_W'(1) << lg_q;
	assign mask     = IDX_W'(lines - CNT_W'(1));
	assign fill_cur = fill_q[part_q];
	assign room     = fill_cur < lines;
	assign vic_i    = !fa_q ? idx_q : (room ? fill_cur[IDX_W-1:0] : (oldest_q[part_q] & mask));
	assign wr_slot  = part_q ? ADDR_W'(MAX_LINES) + ADDR_W'(vic_i) : ADDR_W'(vic_i);
	assign we       = (state_q == S_WRITE);

	chm_tag_ram #(
		.DEPTH (DEPTH),
		.AW    (ADDR_W),
		.DW    (TAG_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_slot),
		.wdata (tag_q),
		.re    (issue),
		.raddr (rd_slot),
		.rdata (rdata)
	);

	// Item registers, loaded when an item is accepted, and compare-stage registers, loaded on each read.
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q  <= TAG_W'(in_addr >> sh_in);
			idx_q  <= in_addr[OFF +: IDX_W] & mask_in;
			part_q <= cfg.split & in_kind;
			fa_q   <= cfg.fa;
			lg_q   <= lg_in;
			n_q    <= cfg.fa ? lines_in : CNT_W'(1);
		end
		if (issue) begin
			cmp_slot_s1 <= rd_slot;
			cmp_last_s1 <= (cnt_q + CNT_W'(1)) == n_q;
		end
	end

	// Sequencer, scan counter and compare pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (cmp_vld_s1 && cmp_last_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Valid bits and FIFO pointers, updated on a miss.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			oldest_q[0] <= '0;
			oldest_q[1] <= '0;
		end else if (we) begin
			valid_q[wr_slot] <= 1'b1;
			if (fa_q) begin
				if (room) begin
					fill_q[part_q] <= fill_cur + CNT_W'(1);
				end else begin
					oldest_q[part_q] <= (vic_i + IDX_W'(1)) & mask;
				end
			end
		end
	end

	assign res.done = (state_q == S_DONE) && out_free;
	assign res.hit  = hit_q;

endmodule

// ===== design/chm_checker.sv =====
`include "cache_hit_model_dm_fa_fifo_macros.svh"

module chm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata
);

	// A stalled result keeps its payload.
	`CHM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed while stalled")

	// The sequencer leaves idle as soon as it takes an item.
	`CHM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an accept")

	// Hits can never outnumber accesses.
	`CHM_ASSERT(a_hits_bounded, !m_axis_tvalid || (m_axis_tdata[128:65] <= m_axis_tdata[64:1]), "hit total above access total")

	// A reported hit is counted in the hit total.
	`CHM_ASSERT(a_hit_counted, !(m_axis_tvalid && m_axis_tdata[0]) || (m_axis_tdata[128:65] != 64'd0), "hit reported with zero hit total")

endmodule

bind cache_hit_model_dm_fa_fifo chm_checker u_chm_checker (.*);

// ===== test/cache_hit_model_dm_fa_fifo_tb.sv =====
`timescale 1ns / 1ps

module cache_hit_model_dm_fa_fifo_tb;
	import chm_pkg::*;

	localparam int MAX_LINES   = MAX_LINES_DEF;
	localparam int OFFSET_BITS = $clog2(LINE_BYTES_DEF);
	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	typedef struct {
		logic [31:0] address;
		logic        kind;
	} mem_access_t;

	typedef struct {
		logic        hit;
		logic [63:0] access_total;
		logic [63:0] hit_total;
	} lookup_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = CFG_FA;
	logic [2:0]   cfg_wdata = 3'd0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = 32'd0;   // address[31:0]
	logic [0:0]   s_axis_tuser = 1'b0;    // access_kind[0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;           // hit[0], access_total[64:1], hit_total[128:65]

	// Items waiting to be driven and lookups waiting to come out.
	mem_access_t    pending_accesses[$];
	lookup_result_t expected_lookups[$];
	mem_access_t    next_access;
	lookup_result_t want;

	// Shadow of the tag store and its configuration.
	logic [25:0] tag_store [2*MAX_LINES];
	logic        tag_valid [2*MAX_LINES];
	logic [6:0]  fifo_count [2];
	logic [5:0]  fifo_head [2];
	logic [63:0] access_count = 64'd0;
	logic [63:0] hit_count = 64'd0;
	logic        cfg_fa = 1'b0;
	logic        cfg_split = 1'b0;
	logic [2:0]  cfg_lg = LG_RESET;

	// Flow control state of the driver and the monitor.
	bit          tx_busy = 1'b0;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	bit          rx_ready = 1'b0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_hold = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned setting_count = 0;

	cache_hit_model_dm_fa_fifo dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < 2*MAX_LINES; i++) begin
			tag_valid[i] = 1'b0;
			tag_store[i] = '0;
		end
		fifo_count[0] = '0;
		fifo_count[1] = '0;
		fifo_head[0] = '0;
		fifo_head[1] = '0;
	end

	// Line count exponent after saturation to the size of a partition.
	function automatic int unsigned eff_log2(logic [2:0] lg);
		int unsigned l;
		l = lg;
		while (l > 0 && (1 << l) > MAX_LINES)
			l--;
		return l;
	endfunction

	// Looks one access up in the shadow store and updates it as the block does.
	function automatic lookup_result_t predict_lookup(logic [31:0] address, logic kind);
		lookup_result_t r;
		int unsigned lg;
		int unsigned lines;
		int unsigned part;
		int unsigned base;
		int unsigned slot;
		logic [25:0] tag;
		r.hit = 1'b0;
		lg = eff_log2(cfg_lg);
		lines = 1 << lg;
		part = cfg_split ? kind : 0;
		base = part * MAX_LINES;
		access_count++;
		if (!cfg_fa) begin
			slot = base + ((address >> OFFSET_BITS) & (lines - 1));
			tag = 26'(address >> (OFFSET_BITS + lg));
			if (tag_valid[slot] && tag_store[slot] == tag) begin
				r.hit = 1'b1;
			end else begin
				tag_store[slot] = tag;
				tag_valid[slot] = 1'b1;
			end
		end else begin
			tag = 26'(address >> OFFSET_BITS);
			for (int i = 0; i < lines; i++)
				if (tag_valid[base + i] && tag_store[base + i] == tag)
					r.hit = 1'b1;
			if (!r.hit) begin
				// Free lines fill in order; a full partition replaces its oldest line.
				if (fifo_count[part] < lines) begin
					slot = fifo_count[part];
					fifo_count[part]++;
				end else begin
					slot = fifo_head[part] & (lines - 1);
					fifo_head[part] = 6'((slot + 1) & (lines - 1));
				end
				tag_store[base + slot] = tag;
				tag_valid[base + slot] = 1'b1;
			end
		end
		if (r.hit)
			hit_count++;
		r.access_total = access_count;
		r.hit_total = hit_count;
		return r;
	endfunction

	// Idle length: mostly none, sometimes short, rarely long.
	function automatic int unsigned pick_gap(bit idle_on);
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_access(logic [31:0] address, logic kind);
		mem_access_t a;
		a.address = address;
		a.kind = kind;
		pending_accesses.push_back(a);
	endtask

	// Returns at a rising edge once every item is in and every lookup is out.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_accesses.size() != 0 || tx_busy || expected_lookups.size() != 0);
		@(posedge clk);
	endtask

	// Writes all three registers one after another; called at a rising edge.
	task automatic apply_config(logic fa, logic split, logic [2:0] lg);
		cfg_fa = fa;
		cfg_split = split;
		cfg_lg = lg;
		setting_count++;
		cfg_we <= 1'b1;
		cfg_index <= CFG_FA;
		cfg_wdata <= {2'b00, fa};
		@(posedge clk);
		cfg_index <= CFG_SPLIT;
		cfg_wdata <= {2'b00, split};
		@(posedge clk);
		cfg_index <= CFG_LG;
		cfg_wdata <= lg;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: offers the next pending item and predicts each one accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_lookups.push_back(predict_lookup(s_axis_tdata, s_axis_tuser[0]));
				tx_busy = 1'b0;
			end
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_accesses.size() != 0) begin
					next_access = pending_accesses.pop_front();
					s_axis_tdata <= next_access.address;
					s_axis_tuser <= next_access.kind;
					tx_busy = 1'b1;
					tx_gap = pick_gap(tx_idle);
				end
			end
			s_axis_tvalid <= tx_busy;
		end
	end

	// Monitor: checks each result against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_lookups.size() == 0) begin
					$error("result item with no expected lookup pending");
					mismatch_count++;
				end else begin
					want = expected_lookups.pop_front();
					if (m_axis_tdata[0] !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
						mismatch_count++;
					end
					if (m_axis_tdata[64:1] !== want.access_total) begin
						$error("access_total: expected %0d, got %0d",
							want.access_total, m_axis_tdata[64:1]);
						mismatch_count++;
					end
					if (m_axis_tdata[128:65] !== want.hit_total) begin
						$error("hit_total: expected %0d, got %0d",
							want.hit_total, m_axis_tdata[128:65]);
						mismatch_count++;
					end
				end
				results_seen++;
				rx_gap = pick_gap(rx_idle);
				// Two long hold-offs so the block backs up and stalls its input.
				if (results_seen == 300 || results_seen == 1100)
					rx_hold = 400;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rx_ready = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rx_ready = 1'b0;
			end else begin
				rx_ready = 1'b1;
			end
			m_axis_tready <= rx_ready;
		end
	end

	// Stimulus: directed checks, then random phases under changing settings.
	initial begin
		bit [4:0] presets [0:7] = '{5'b00000, 5'b01110, 5'b10110, 5'b11000,
			5'b11111, 5'b00111, 5'b10011, 5'b01010};
		logic [31:0] line_pool[$];
		logic [31:0] region;
		logic [31:0] address;
		logic        fa;
		logic        split;
		logic [2:0]  lg;
		int unsigned lines;
		int unsigned pool_n;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: direct mapped, unified, 64 lines; kind is ignored.
		queue_access(32'h0000_0000, KIND_INSTR);
		queue_access(32'h0000_003F, KIND_DATA);
		queue_access(32'hFFFF_FFFF, KIND_INSTR);
		queue_access(32'hFFFF_FFC0, KIND_DATA);
		queue_access(32'h0000_1000, KIND_INSTR);
		queue_access(32'h0000_0000, KIND_INSTR);
		queue_access(32'h0000_1000, KIND_DATA);
		wait_idle();

		// Split with an oversized exponent; the instruction half keeps its lines.
		apply_config(1'b0, 1'b1, 3'd7);
		queue_access(32'h0000_1000, KIND_INSTR);
		queue_access(32'h0000_1000, KIND_DATA);
		queue_access(32'h0000_1000, KIND_DATA);
		wait_idle();

		// Fully associative, two lines per half, over tags left by direct mapping.
		apply_config(1'b1, 1'b1, 3'd1);
		queue_access(32'h0000_0040, KIND_INSTR);
		queue_access(32'h8000_0000, KIND_INSTR);
		queue_access(32'h8000_0040, KIND_INSTR);
		queue_access(32'h8000_0080, KIND_INSTR);
		queue_access(32'h8000_0000, KIND_INSTR);
		queue_access(32'h8000_0080, KIND_INSTR);
		queue_access(32'h8000_0000, KIND_DATA);
		wait_idle();

		// One line, unified, with a fill count already above the line count.
		apply_config(1'b1, 1'b0, 3'd0);
		queue_access(32'h7FFF_FFC0, KIND_INSTR);
		queue_access(32'h7FFF_FFFF, KIND_DATA);
		queue_access(32'h0000_0000, KIND_DATA);
		wait_idle();

		// Direct mapped with one line: the tag is every bit above the offset.
		apply_config(1'b0, 1'b0, 3'd0);
		queue_access(32'h5555_5555, KIND_INSTR);
		queue_access(32'hAAAA_AAAA, KIND_INSTR);
		queue_access(32'hAAAA_AAAB, KIND_DATA);
		wait_idle();

		// Random phases over a working set sized near the line count.
		for (int ph = 0; ph < 16; ph++) begin
			if (ph < 8) begin
				{fa, split, lg} = presets[ph];
			end else begin
				fa = 1'($urandom_range(0, 1));
				split = 1'($urandom_range(0, 1));
				lg = 3'($urandom_range(0, 7));
			end
			tx_idle = ($urandom_range(0, 9) > 2);
			rx_idle = ($urandom_range(0, 9) > 2);
			apply_config(fa, split, lg);

			lines = 1 << eff_log2(lg);
			pool_n = $urandom_range(lines / 2 + 1, 2 * lines + 2);
			region = $urandom;
			line_pool.delete();
			for (int k = 0; k < pool_n; k++)
				if ($urandom_range(0, 3) == 0)
					line_pool.push_back($urandom);
				else
					line_pool.push_back(region + ($urandom_range(0, 4 * lines - 1) << OFFSET_BITS));

			for (int n = 0; n < 105; n++) begin
				if ($urandom_range(0, 99) < 12)
					address = $urandom;
				else
					address = {line_pool[$urandom_range(0, pool_n - 1)][31:OFFSET_BITS],
						OFFSET_BITS'($urandom)};
				queue_access(address, 1'($urandom_range(0, 1)));
			end
			wait_idle();
		end

		repeat (80) @(posedge clk);
		$display("Summary: %0d accesses with %0d hits under %0d cache settings,",
			access_count, hit_count, setting_count + 1);
		$display("covering direct mapped, FIFO, split, unified and saturated sizes.");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Safety limit well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/chm_pkg.sv
design/chm_tag_ram.sv
design/chm_lookup.sv
design/cache_hit_model_dm_fa_fifo.sv
design/chm_checker.sv
test/cache_hit_model_dm_fa_fifo_tb.sv
